// File: rtl/core/box_check_and_backproject_core_assert.svh
`ifndef BOX_CHECK_AND_BACKPROJECT_CORE_ASSERT_SVH
`define BOX_CHECK_AND_BACKPROJECT_CORE_ASSERT_SVH

// A condition that must hold in the same cycle as its trigger.
`define BCB_ASSERT_SAME(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("bcb: same-cycle check failed");

// A condition that must hold in the cycle after its trigger.
`define BCB_ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("bcb: next-cycle check failed");

// A next-cycle check that stays armed during reset.
`define BCB_ASSERT_RESET(label, clk, pre, post) \
    label: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("bcb: reset check failed");

`endif

// File: rtl/core/bcb_pkg.sv
package bcb_pkg;

    localparam int IMAGE_WIDTH   = 640;
    localparam int IMAGE_HEIGHT  = 480;
    localparam int BORDER_MARGIN = 5;
    localparam int SMALL_DIVISOR = 20;
    localparam int OFFC_FACTOR   = 10;

    localparam int LEFT_W = 10;
    localparam int TOP_W  = 9;
    localparam int WID_W  = 10;
    localparam int HGT_W  = 9;
    localparam int POS_W  = 24;
    localparam int HEAD_W = 16;
    localparam int STAT_W = 2;
    localparam int OUT_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_HGT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd7;

    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BORDER     = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_SMALL      = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_OFF_CENTER = 2'd3;

    localparam int CORDIC_STEPS = 20;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
        32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2E,
        32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9,
        32'sh0000517C, 32'sh000028BE, 32'sh0000145F, 32'sh00000A2F, 32'sh00000517
    };

    // Dividend width covers object height * focal_y * |dx| plus the rounding half.
    localparam int DIV_NW   = 45;
    localparam int DEPTH_DW = 13;
    localparam int RIGHT_DW = 26;
    localparam int DOWN_DW  = 10;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic                    neg_x;
        logic                    neg_y;
        logic signed [POS_W-1:0] rx;
        logic signed [POS_W-1:0] ry;
        logic [HEAD_W-1:0]       heading;
    } div_side_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [31:0]      fwd;
        logic signed [31:0]      lft;
        logic signed [OUT_W-1:0] wz;
        logic signed [POS_W-1:0] rx;
        logic signed [POS_W-1:0] ry;
    } rot_side_t;

endpackage

// File: rtl/core/box_check_and_backproject_core.sv
// Channel   | Handshake          | Word
// ----------+--------------------+-------------------------------------------------
// box in    | s_valid / s_ready  | box left, top, width, height; robot x, y, heading
// result    | m_valid / m_ready  | status, world x, y, z
// config    | cfg_wr_en          | cfg_index, cfg_wr_data (write only, no wait)
//
// One word is accepted every cycle while s_ready is high.
// The pipeline depth is set by the 45-stage restoring dividers and the 21-stage heading CORDIC.
// Reset (aresetn low, synchronous) clears all valid bits and loads the register defaults.
// When a result is held at the output, the pipeline still advances while the last stage is empty;
// s_ready drops only when the output is held and the last stage before it is occupied.
module box_check_and_backproject_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bcb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcb_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bcb_pkg::LEFT_W-1:0]          s_box_left,
    input  logic [bcb_pkg::TOP_W-1:0]           s_box_top,
    input  logic [bcb_pkg::WID_W-1:0]           s_box_width,
    input  logic [bcb_pkg::HGT_W-1:0]           s_box_height,
    input  logic signed [bcb_pkg::POS_W-1:0]    s_robot_x,
    input  logic signed [bcb_pkg::POS_W-1:0]    s_robot_y,
    input  logic [bcb_pkg::HEAD_W-1:0]          s_robot_heading,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bcb_pkg::STAT_W-1:0]          m_status,
    output logic signed [bcb_pkg::OUT_W-1:0]    m_world_x,
    output logic signed [bcb_pkg::OUT_W-1:0]    m_world_y,
    output logic signed [bcb_pkg::OUT_W-1:0]    m_world_z
);
    import bcb_pkg::*;

    localparam logic [13:0] BORDER_LO    = 14'(BORDER_MARGIN);
    localparam logic [13:0] BORDER_RIGHT = 14'(IMAGE_WIDTH - BORDER_MARGIN);
    localparam logic [13:0] BORDER_BOT   = 14'(IMAGE_HEIGHT - BORDER_MARGIN);
    localparam logic [14:0] SMALL_W      = 15'(IMAGE_WIDTH);
    localparam logic [14:0] SMALL_H      = 15'(IMAGE_HEIGHT);
    localparam logic [16:0] OFFC_W       = 17'(IMAGE_WIDTH);
    localparam logic [16:0] OFFC_H       = 17'(IMAGE_HEIGHT);
    localparam logic signed [46:0] BASE_HI = 47'sd2147483647;
    localparam logic signed [46:0] BASE_LO = -47'sd2147483647;
    localparam logic signed [46:0] WZ_HI   = 47'sd8388607;
    localparam logic signed [46:0] WZ_LO   = -47'sd8388608;
    localparam logic signed [36:0] OUT_HI  = 37'sd8388607;
    localparam logic signed [36:0] OUT_LO  = -37'sd8388608;
    localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;

    // Configuration registers
    logic [15:0]        focal_x_reg;
    logic [15:0]        focal_y_reg;
    logic [10:0]        center_x_reg;
    logic [9:0]         center_y_reg;
    logic [15:0]        obj_hgt_reg;
    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic signed [15:0] offset_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= 16'd6101;
            focal_y_reg  <= 16'd6101;
            center_x_reg <= 11'd641;
            center_y_reg <= 10'd481;
            obj_hgt_reg  <= 16'd418;
            offset_x_reg <= 16'sd200;
            offset_y_reg <= 16'sd200;
            offset_z_reg <= 16'sd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FOCAL_X:  focal_x_reg  <= cfg_wr_data;
                CFG_FOCAL_Y:  focal_y_reg  <= cfg_wr_data;
                CFG_CENTER_X: center_x_reg <= cfg_wr_data[10:0];
                CFG_CENTER_Y: center_y_reg <= cfg_wr_data[9:0];
                CFG_OBJ_HGT:  obj_hgt_reg  <= cfg_wr_data;
                CFG_OFFSET_X: offset_x_reg <= $signed(cfg_wr_data);
                CFG_OFFSET_Y: offset_y_reg <= $signed(cfg_wr_data);
                CFG_OFFSET_Z: offset_z_reg <= $signed(cfg_wr_data);
                default: ;
            endcase
        end
    end

    // Flow control: the output register loads when empty or taken; the pipeline
    // advances whenever the output loads or the stage in front of it is empty.
    logic m2_valid_reg;
    logic m_valid_reg;
    logic out_en;
    logic adv;

    assign out_en  = !m_valid_reg || m_ready;
    assign adv     = out_en || !m2_valid_reg;
    assign s_ready = adv;

    // Stage 1: box checks and centre offsets
    logic [11:0]        u2;
    logic signed [13:0] dx;
    logic [11:0]        dx_abs;
    logic [10:0]        v2;
    logic signed [11:0] dy;
    logic [10:0]        dy_abs;
    logic               is_border;
    logic               is_small;
    logic               is_offc;
    logic [STAT_W-1:0]  status_next;

    assign u2     = 12'({s_box_left, 1'b0}) + 12'(s_box_width);
    assign dx     = $signed({2'b00, u2}) - $signed({3'b000, center_x_reg});
    assign dx_abs = dx[13] ? 12'(-dx) : dx[11:0];
    assign v2     = 11'({s_box_top, 1'b0}) + 11'(s_box_height);
    assign dy     = $signed({1'b0, v2}) - $signed({2'b00, center_y_reg});
    assign dy_abs = dy[11] ? 11'(-dy) : dy[10:0];

    assign is_border = (14'(s_box_left) < BORDER_LO)
                    || (14'(s_box_left) + 14'(s_box_width) > BORDER_RIGHT)
                    || (14'(s_box_top) < BORDER_LO)
                    || (14'(s_box_top) + 14'(s_box_height) > BORDER_BOT);
    assign is_small  = (15'(s_box_width) * 15'(SMALL_DIVISOR) < SMALL_W)
                    || (15'(s_box_height) * 15'(SMALL_DIVISOR) < SMALL_H);
    assign is_offc   = (17'(dx_abs) * 17'(OFFC_FACTOR) > OFFC_W)
                    || (17'(dy_abs) * 17'(OFFC_FACTOR) > OFFC_H);

    always_comb begin
        if (is_border) begin
            status_next = STATUS_BORDER;
        end else if (is_small) begin
            status_next = STATUS_SMALL;
        end else if (is_offc) begin
            status_next = STATUS_OFF_CENTER;
        end else begin
            status_next = STATUS_OK;
        end
    end

    logic             s1_valid_reg;
    div_side_t        s1_side_reg;
    logic [11:0]      s1_dx_abs_reg;
    logic [10:0]      s1_dy_abs_reg;
    logic [HGT_W-1:0] s1_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_side_reg.status  <= status_next;
            s1_side_reg.neg_x   <= dx[13];
            s1_side_reg.neg_y   <= dy[11];
            s1_side_reg.rx      <= s_robot_x;
            s1_side_reg.ry      <= s_robot_y;
            s1_side_reg.heading <= s_robot_heading;
            s1_dx_abs_reg       <= dx_abs;
            s1_dy_abs_reg       <= dy_abs;
            s1_h_reg            <= s_box_height;
        end
    end

    // Stage 2: object height * focal_y and box height * focal_x
    logic [15:0]      fx_eff;
    logic             s2_valid_reg;
    div_side_t        s2_side_reg;
    logic [31:0]      s2_hf_reg;
    logic [24:0]      s2_hx_reg;
    logic [11:0]      s2_dx_abs_reg;
    logic [10:0]      s2_dy_abs_reg;
    logic [HGT_W-1:0] s2_h_reg;

    // A zero focal_x divides as one.
    assign fx_eff = (focal_x_reg == '0) ? 16'd1 : focal_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_side_reg   <= s1_side_reg;
            s2_hf_reg     <= 32'(obj_hgt_reg) * 32'(focal_y_reg);
            s2_hx_reg     <= 25'(s1_h_reg) * 25'(fx_eff);
            s2_dx_abs_reg <= s1_dx_abs_reg;
            s2_dy_abs_reg <= s1_dy_abs_reg;
            s2_h_reg      <= s1_h_reg;
        end
    end

    // Stage 3: numerator products
    logic             s3_valid_reg;
    div_side_t        s3_side_reg;
    logic [43:0]      s3_nr_prod_reg;
    logic [26:0]      s3_nd_prod_reg;
    logic [32:0]      s3_n_depth_reg;
    logic [24:0]      s3_hx_reg;
    logic [HGT_W-1:0] s3_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_side_reg    <= s2_side_reg;
            s3_nr_prod_reg <= 44'(s2_hf_reg) * 44'(s2_dx_abs_reg);
            s3_nd_prod_reg <= 27'(obj_hgt_reg) * 27'(s2_dy_abs_reg);
            s3_n_depth_reg <= 33'(s2_hf_reg) + 33'({s2_h_reg, 3'b000});
            s3_hx_reg      <= s2_hx_reg;
            s3_h_reg       <= s2_h_reg;
        end
    end

    // Stage 4: add half the divisor for rounding to nearest
    logic                s4_valid_reg;
    div_side_t           s4_side_reg;
    logic [DIV_NW-1:0]   s4_n_depth_reg;
    logic [DIV_NW-1:0]   s4_n_right_reg;
    logic [DIV_NW-1:0]   s4_n_down_reg;
    logic [DEPTH_DW-1:0] s4_d_depth_reg;
    logic [RIGHT_DW-1:0] s4_d_right_reg;
    logic [DOWN_DW-1:0]  s4_d_down_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (adv) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_side_reg    <= s3_side_reg;
            s4_n_depth_reg <= DIV_NW'(s3_n_depth_reg);
            s4_n_right_reg <= DIV_NW'(s3_nr_prod_reg) + DIV_NW'(s3_hx_reg);
            s4_n_down_reg  <= DIV_NW'(s3_nd_prod_reg) + DIV_NW'(s3_h_reg);
            s4_d_depth_reg <= {s3_h_reg, 4'b0000};
            s4_d_right_reg <= {s3_hx_reg, 1'b0};
            s4_d_down_reg  <= {s3_h_reg, 1'b0};
        end
    end

    // Dividers
    logic              dv_valid;
    div_side_t         dv_side;
    logic [DIV_NW-1:0] q_depth;
    logic [DIV_NW-1:0] q_right;
    logic [DIV_NW-1:0] q_down;

    bcb_div #(
        .NW (DIV_NW),
        .DW (DEPTH_DW),
        .SW ($bits(div_side_t))
    ) u_div_depth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s4_valid_reg),
        .num       (s4_n_depth_reg),
        .den       (s4_d_depth_reg),
        .side_i    (s4_side_reg),
        .out_valid (dv_valid),
        .quot      (q_depth),
        .side_o    (dv_side)
    );

    bcb_div #(
        .NW (DIV_NW),
        .DW (RIGHT_DW),
        .SW (1)
    ) u_div_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s4_valid_reg),
        .num       (s4_n_right_reg),
        .den       (s4_d_right_reg),
        .side_i    (1'b0),
        .out_valid (),
        .quot      (q_right),
        .side_o    ()
    );

    bcb_div #(
        .NW (DIV_NW),
        .DW (DOWN_DW),
        .SW (1)
    ) u_div_down (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s4_valid_reg),
        .num       (s4_n_down_reg),
        .den       (s4_d_down_reg),
        .side_i    (1'b0),
        .out_valid (),
        .quot      (q_down),
        .side_o    ()
    );

    // Base frame: add camera offsets and saturate
    logic signed [46:0] fwd_sum;
    logic signed [46:0] lft_sum;
    logic signed [46:0] wz_sum;
    logic signed [31:0] fwd_sat;
    logic signed [31:0] lft_sat;
    logic signed [OUT_W-1:0] wz_sat;

    assign fwd_sum = 47'(offset_x_reg) + $signed({2'b00, q_depth});
    assign lft_sum = dv_side.neg_x ? 47'(offset_y_reg) + $signed({2'b00, q_right})
                                   : 47'(offset_y_reg) - $signed({2'b00, q_right});
    assign wz_sum  = dv_side.neg_y ? 47'(offset_z_reg) + $signed({2'b00, q_down})
                                   : 47'(offset_z_reg) - $signed({2'b00, q_down});

    always_comb begin
        if (fwd_sum > BASE_HI) begin
            fwd_sat = BASE_HI[31:0];
        end else if (fwd_sum < BASE_LO) begin
            fwd_sat = BASE_LO[31:0];
        end else begin
            fwd_sat = fwd_sum[31:0];
        end
        if (lft_sum > BASE_HI) begin
            lft_sat = BASE_HI[31:0];
        end else if (lft_sum < BASE_LO) begin
            lft_sat = BASE_LO[31:0];
        end else begin
            lft_sat = lft_sum[31:0];
        end
        if (wz_sum > WZ_HI) begin
            wz_sat = WZ_HI[OUT_W-1:0];
        end else if (wz_sum < WZ_LO) begin
            wz_sat = WZ_LO[OUT_W-1:0];
        end else begin
            wz_sat = wz_sum[OUT_W-1:0];
        end
    end

    logic              bp_valid_reg;
    rot_side_t         bp_side_reg;
    logic [HEAD_W-1:0] bp_heading_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_valid_reg <= 1'b0;
        end else if (adv) begin
            bp_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bp_side_reg.status <= dv_side.status;
            bp_side_reg.fwd    <= fwd_sat;
            bp_side_reg.lft    <= lft_sat;
            bp_side_reg.wz     <= wz_sat;
            bp_side_reg.rx     <= dv_side.rx;
            bp_side_reg.ry     <= dv_side.ry;
            bp_heading_reg     <= dv_side.heading;
        end
    end

    // Heading rotation
    logic               rot_valid;
    logic signed [31:0] rot_cos;
    logic signed [31:0] rot_sin;
    rot_side_t          rot_side;

    bcb_cordic #(
        .SW ($bits(rot_side_t))
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (bp_valid_reg),
        .heading   (bp_heading_reg),
        .side_i    (bp_side_reg),
        .out_valid (rot_valid),
        .cos_o     (rot_cos),
        .sin_o     (rot_sin),
        .side_o    (rot_side)
    );

    // M1: the four rotation products
    logic               m1_valid_reg;
    logic [STAT_W-1:0]  m1_status_reg;
    logic signed [OUT_W-1:0] m1_wz_reg;
    logic signed [POS_W-1:0] m1_rx_reg;
    logic signed [POS_W-1:0] m1_ry_reg;
    logic signed [63:0] m1_cf_reg;
    logic signed [63:0] m1_sl_reg;
    logic signed [63:0] m1_sf_reg;
    logic signed [63:0] m1_cl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (adv) begin
            m1_valid_reg <= rot_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_status_reg <= rot_side.status;
            m1_wz_reg     <= rot_side.wz;
            m1_rx_reg     <= rot_side.rx;
            m1_ry_reg     <= rot_side.ry;
            m1_cf_reg     <= 64'(rot_cos) * 64'(rot_side.fwd);
            m1_sl_reg     <= 64'(rot_sin) * 64'(rot_side.lft);
            m1_sf_reg     <= 64'(rot_sin) * 64'(rot_side.fwd);
            m1_cl_reg     <= 64'(rot_cos) * 64'(rot_side.lft);
        end
    end

    // M2: sum, round and drop the Q30 fraction
    logic signed [65:0] sum_x;
    logic signed [65:0] sum_y;

    assign sum_x = 66'(m1_cf_reg) - 66'(m1_sl_reg) + ROUND_HALF;
    assign sum_y = 66'(m1_sf_reg) + 66'(m1_cl_reg) + ROUND_HALF;

    logic               m2_status_ok_reg;
    logic [STAT_W-1:0]  m2_status_reg;
    logic signed [OUT_W-1:0] m2_wz_reg;
    logic signed [POS_W-1:0] m2_rx_reg;
    logic signed [POS_W-1:0] m2_ry_reg;
    logic signed [35:0] m2_sx_reg;
    logic signed [35:0] m2_sy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (adv) begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_status_reg    <= m1_status_reg;
            m2_status_ok_reg <= (m1_status_reg == STATUS_OK);
            m2_wz_reg        <= m1_wz_reg;
            m2_rx_reg        <= m1_rx_reg;
            m2_ry_reg        <= m1_ry_reg;
            m2_sx_reg        <= sum_x[65:30];
            m2_sy_reg        <= sum_y[65:30];
        end
    end

    // Output register: translate by robot position and saturate; rejected boxes give zero
    logic signed [36:0]      wx_sum;
    logic signed [36:0]      wy_sum;
    logic signed [OUT_W-1:0] wx_next;
    logic signed [OUT_W-1:0] wy_next;
    logic signed [OUT_W-1:0] wz_next;

    assign wx_sum = 37'(m2_rx_reg) + 37'(m2_sx_reg);
    assign wy_sum = 37'(m2_ry_reg) + 37'(m2_sy_reg);

    always_comb begin
        if (!m2_status_ok_reg) begin
            wx_next = '0;
        end else if (wx_sum > OUT_HI) begin
            wx_next = OUT_HI[OUT_W-1:0];
        end else if (wx_sum < OUT_LO) begin
            wx_next = OUT_LO[OUT_W-1:0];
        end else begin
            wx_next = wx_sum[OUT_W-1:0];
        end
        if (!m2_status_ok_reg) begin
            wy_next = '0;
        end else if (wy_sum > OUT_HI) begin
            wy_next = OUT_HI[OUT_W-1:0];
        end else if (wy_sum < OUT_LO) begin
            wy_next = OUT_LO[OUT_W-1:0];
        end else begin
            wy_next = wy_sum[OUT_W-1:0];
        end
        wz_next = m2_status_ok_reg ? m2_wz_reg : '0;
    end

    logic [STAT_W-1:0]       m_status_reg;
    logic signed [OUT_W-1:0] m_world_x_reg;
    logic signed [OUT_W-1:0] m_world_y_reg;
    logic signed [OUT_W-1:0] m_world_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_status_reg  <= m2_status_reg;
            m_world_x_reg <= wx_next;
            m_world_y_reg <= wy_next;
            m_world_z_reg <= wz_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_world_x = m_world_x_reg;
    assign m_world_y = m_world_y_reg;
    assign m_world_z = m_world_z_reg;

endmodule

// File: rtl/core/bcb_div.sv
module bcb_div #(
    parameter int NW = 45,
    parameter int DW = 13,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_i,
    output logic          out_valid,
    output logic [NW-1:0] quot,
    output logic [SW-1:0] side_o
);
    // Restoring division, one quotient bit per stage, most significant first.
    logic          valid_reg [NW];
    logic [DW-1:0] rem_reg   [NW];
    logic [NW-1:0] num_reg   [NW];
    logic [NW-1:0] quot_reg  [NW];
    logic [DW-1:0] den_reg   [NW];
    logic [SW-1:0] side_reg  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          valid_src;
        logic [DW-1:0] rem_src;
        logic [NW-1:0] num_src;
        logic [NW-1:0] quot_src;
        logic [DW-1:0] den_src;
        logic [SW-1:0] side_src;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign valid_src = in_valid;
            assign rem_src   = '0;
            assign num_src   = num;
            assign quot_src  = '0;
            assign den_src   = den;
            assign side_src  = side_i;
        end else begin : g_next
            assign valid_src = valid_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign num_src   = num_reg[k-1];
            assign quot_src  = quot_reg[k-1];
            assign den_src   = den_reg[k-1];
            assign side_src  = side_reg[k-1];
        end

        assign trial = {rem_src, num_src[NW-1]};
        assign ge    = trial >= {1'b0, den_src};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
                num_reg[k]  <= {num_src[NW-2:0], 1'b0};
                quot_reg[k] <= {quot_src[NW-2:0], ge};
                den_reg[k]  <= den_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign quot      = quot_reg[NW-1];
    assign side_o    = side_reg[NW-1];

endmodule

// File: rtl/core/bcb_cordic.sv
module bcb_cordic #(
    parameter int SW = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [bcb_pkg::HEAD_W-1:0]  heading,
    input  logic [SW-1:0]               side_i,
    output logic                        out_valid,
    output logic signed [31:0]          cos_o,
    output logic signed [31:0]          sin_o,
    output logic [SW-1:0]               side_o
);
    import bcb_pkg::*;

    logic               valid_reg [0:CORDIC_STEPS];
    logic signed [31:0] x_reg     [0:CORDIC_STEPS];
    logic signed [31:0] y_reg     [0:CORDIC_STEPS];
    logic signed [31:0] z_reg     [0:CORDIC_STEPS];
    logic               flip_reg  [0:CORDIC_STEPS];
    logic [SW-1:0]      side_reg  [0:CORDIC_STEPS];

    logic [31:0] angle;
    logic [31:0] angle_shift;
    logic        fold;

    // Angles in the back half turn are rotated by half a turn and the result negated.
    assign angle       = {heading, 16'h0000};
    assign angle_shift = angle + 32'h4000_0000;
    assign fold        = angle_shift[31];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= fold ? $signed(angle ^ 32'h8000_0000) : $signed(angle);
            flip_reg[0] <= fold;
            side_reg[0] <= side_i;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [31:0] xs;
        logic signed [31:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i+1] <= 1'b0;
            end else if (en) begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][31]) begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_TURN[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_TURN[i];
                end
                flip_reg[i+1] <= flip_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign cos_o     = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign sin_o     = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    assign side_o    = side_reg[CORDIC_STEPS];

endmodule

// File: rtl/core/bcb_checker.sv
`include "box_check_and_backproject_core_assert.svh"

module bcb_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [bcb_pkg::STAT_W-1:0]          m_status,
    input logic signed [bcb_pkg::OUT_W-1:0]    m_world_x,
    input logic signed [bcb_pkg::OUT_W-1:0]    m_world_y,
    input logic signed [bcb_pkg::OUT_W-1:0]    m_world_z
);
    import bcb_pkg::*;

    // A taken result always frees a slot, so the input side cannot stall then.
    `BCB_ASSERT_SAME(a_ready_follows_out, aclk, aresetn, m_ready, s_ready)

    // A rejected box carries a zero position.
    `BCB_ASSERT_SAME(a_reject_zero, aclk, aresetn, m_valid && (m_status != STATUS_OK), (m_world_x == '0) && (m_world_y == '0) && (m_world_z == '0))

    // A result waiting at the output keeps its word.
    `BCB_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_world_x) && $stable(m_world_y) && $stable(m_world_z))

    // Reset empties the pipeline.
    `BCB_ASSERT_RESET(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind box_check_and_backproject_core bcb_checker u_bcb_checker (.*);
